### rtl/bolt_pkg.sv
// ----------------------------------------------------------------------------
// bolt_pkg: shared types and constants for the bounded ordered list table
// Operation codes, fixed field widths, register map and parameter defaults.
// ----------------------------------------------------------------------------
package bolt_pkg;

  // parameter defaults
  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W_DEF = 32;

  // fixed field widths
  localparam int OP_W    = 3;
  localparam int IDX_W   = 4;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;
  localparam int TOTAL_W = 5;

  // config port
  localparam int APB_DW  = 32;
  localparam int PADDR_W = 3;
  localparam int REG_SEL_W = PADDR_W - 2;
  localparam logic [REG_SEL_W-1:0] REG_CAPACITY = '0;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_GET    = 3'd2,
    OP_SET    = 3'd3,
    OP_REMOVE = 3'd4,
    OP_FIND   = 3'd5,
    OP_CLEAR  = 3'd6
  } op_t;

endpackage

### rtl/bolt_if.sv
// ----------------------------------------------------------------------------
// bolt_in_if / bolt_out_if: valid/ready channels of the list table
// Command beats in, result beats out.
// ----------------------------------------------------------------------------
interface bolt_in_if;
  import bolt_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [IDX_W-1:0] index;
  logic [VAL_W-1:0] new_value;

  modport source (output valid, output operation, output index, output new_value,
                  input ready);
  modport sink   (input valid, input operation, input index, input new_value,
                  output ready);
endinterface

interface bolt_out_if;
  import bolt_pkg::*;

  logic               valid;
  logic               ready;
  logic               status;
  logic [VAL_W-1:0]   read_value;
  logic [IDX_W-1:0]   found_index;
  logic [TOTAL_W-1:0] entry_total;
  logic               is_empty;
  logic               is_full;

  modport source (output valid, output status, output read_value, output found_index,
                  output entry_total, output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input read_value, input found_index,
                  input entry_total, input is_empty, input is_full, output ready);
endinterface

### rtl/bounded_ordered_list_table_core.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list_table_core: packed ordered list with shift-down remove
// Path after accept, ending in S_DONE (held until the output slot is free):
//   pop, get: S_RD, S_RD_LATCH; remove at i: S_SH_RD/S_SH_WR per entry above i;
//   find: S_FD_RD/S_FD_CMP per entry to a match or the end; other, failed: none.
// Throughput: one command at a time; the single-port read of the entry RAM
//   and the shared pointer/compare unit set the loop length for remove/find.
// Reset (rst_n, synchronous, active low): count 0, capacity 16, no result
//   pending. Entry RAM is not cleared; cells above the count are never read.
// ----------------------------------------------------------------------------
module bounded_ordered_list_table_core #(
  parameter int DEPTH  = bolt_pkg::DEPTH_DEF,
  parameter int DATA_W = bolt_pkg::DATA_W_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bolt_in_if.sink                       in_if,
  bolt_out_if.source                    out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bolt_pkg::PADDR_W-1:0]  paddr,
  input  logic [bolt_pkg::APB_DW-1:0]   pwdata,
  output logic [bolt_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import bolt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // RAM address
  localparam int CW = $clog2(DEPTH + 1);                // count, holds DEPTH
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;        // compare domain
  localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);
  localparam logic [XW-1:0] ONE_X   = XW'(1);

  // Sequencer: one shared pointer incrementer, reused by the remove shift and the
  // find scan, and one word comparator for the find scan (pop/get only read).
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,        // read issued at ptr
    S_RD_LATCH,  // read data back, capture for pop/get
    S_SH_RD,     // remove: read entry ptr+1
    S_SH_WR,     // remove: write it to entry ptr
    S_FD_RD,     // find: read entry ptr
    S_FD_CMP,    // find: compare against key
    S_DONE       // result ready, wait for output register
  } state_t;

  state_t             state_r;
  logic [CW-1:0]      count_r;
  logic [CAP_W-1:0]   cap_r;
  logic [XW-1:0]      ptr_r;
  logic [DATA_W-1:0]  word_r;
  logic [DATA_W-1:0]  rd_r;
  logic               status_r;
  logic [IDX_W-1:0]   fidx_r;

  // output holding register
  logic               out_valid_r;
  logic               out_status_r;
  logic [VAL_W-1:0]   out_read_r;
  logic [IDX_W-1:0]   out_fidx_r;
  logic [TOTAL_W-1:0] out_total_r;
  logic               out_empty_r;
  logic               out_full_r;

  // entry RAM, one write and one registered read port
  logic [DATA_W-1:0]  mem [DEPTH];
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  logic [DATA_W-1:0]  mem_wdata;
  logic [DATA_W-1:0]  rdata_r;

  logic               accept;
  logic               out_free;
  logic               cfg_wr;
  logic [63:0]        in_ext;
  logic [63:0]        rd_ext;
  logic [DATA_W-1:0]  word_in;
  logic [XW-1:0]      cnt_x;
  logic [XW-1:0]      cap_x;
  logic [XW-1:0]      idx_in_x;
  logic [XW-1:0]      ptr_inc;
  logic               push_ok;
  logic               idx_ok;
  logic               match;

  assign accept   = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;
  assign cfg_wr   = psel && penable && pwrite && pready;

  // key is taken modulo the stored word width
  assign in_ext   = 64'(in_if.new_value);
  assign word_in  = in_ext[DATA_W-1:0];
  assign rd_ext   = 64'(rd_r);

  assign cnt_x    = XW'(count_r);
  assign cap_x    = XW'(cap_r);
  assign idx_in_x = XW'(in_if.index);
  assign ptr_inc  = ptr_r + ONE_X;
  assign push_ok  = (cnt_x < cap_x) && (cnt_x < DEPTH_X);
  assign idx_ok   = idx_in_x < cnt_x;
  assign match    = (rdata_r == word_r);

  // --- config port ---------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_CAPACITY) ? APB_DW'(cap_r) : '0;

  // --- RAM port steering -----------------------------------------------------
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_x[AW-1:0];
    mem_wdata = word_in;
    mem_raddr = ptr_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_if.operation == OP_PUSH && push_ok) begin
            mem_we = 1'b1;
          end else if (in_if.operation == OP_SET && idx_ok) begin
            mem_we    = 1'b1;
            mem_waddr = idx_in_x[AW-1:0];
          end
        end
      end
      S_SH_RD: begin
        mem_raddr = ptr_inc[AW-1:0];
      end
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r[AW-1:0];
        mem_wdata = rdata_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  // --- sequencer and registered outputs ---------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && paddr[PADDR_W-1:2] == REG_CAPACITY) begin
        cap_r <= pwdata[CAP_W-1:0];
      end
      // post a finished command, else drop a beat the sink has taken
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            word_r <= word_in;
            rd_r   <= '0;
            fidx_r <= '0;
            case (in_if.operation)
              OP_PUSH: begin
                status_r <= !push_ok;
                state_r  <= S_DONE;
                if (push_ok) begin
                  count_r <= count_r + CW'(1);
                end
              end
              OP_POP: begin
                status_r <= 1'b1;
                if (count_r != '0) begin
                  count_r <= count_r - CW'(1);
                  ptr_r   <= cnt_x - ONE_X;
                  state_r <= S_RD;
                end else begin
                  state_r <= S_DONE;
                end
              end
              OP_GET: begin
                status_r <= 1'b1;
                if (idx_ok) begin
                  ptr_r   <= idx_in_x;
                  state_r <= S_RD;
                end else begin
                  state_r <= S_DONE;
                end
              end
              OP_SET: begin
                status_r <= !idx_ok;
                state_r  <= S_DONE;
              end
              OP_REMOVE: begin
                if (idx_ok) begin
                  ptr_r <= idx_in_x;
                  if ((idx_in_x + ONE_X) < cnt_x) begin
                    status_r <= 1'b1;
                    state_r  <= S_SH_RD;
                  end else begin
                    // last entry: nothing to shift
                    count_r  <= count_r - CW'(1);
                    status_r <= 1'b0;
                    state_r  <= S_DONE;
                  end
                end else begin
                  status_r <= 1'b1;
                  state_r  <= S_DONE;
                end
              end
              OP_FIND: begin
                status_r <= 1'b1;
                ptr_r    <= '0;
                if (count_r != '0) begin
                  state_r <= S_FD_RD;
                end else begin
                  state_r <= S_DONE;
                end
              end
              OP_CLEAR: begin
                count_r  <= '0;
                status_r <= 1'b0;
                state_r  <= S_DONE;
              end
              default: begin
                // undefined code fails, no change
                status_r <= 1'b1;
                state_r  <= S_DONE;
              end
            endcase
          end
        end
        S_RD: begin
          state_r <= S_RD_LATCH;
        end
        S_RD_LATCH: begin
          rd_r     <= rdata_r;
          status_r <= 1'b0;
          state_r  <= S_DONE;
        end
        S_SH_RD: begin
          state_r <= S_SH_WR;
        end
        S_SH_WR: begin
          ptr_r <= ptr_inc;
          if ((ptr_inc + ONE_X) < cnt_x) begin
            state_r <= S_SH_RD;
          end else begin
            count_r  <= count_r - CW'(1);
            status_r <= 1'b0;
            state_r  <= S_DONE;
          end
        end
        S_FD_RD: begin
          state_r <= S_FD_CMP;
        end
        S_FD_CMP: begin
          if (match) begin
            status_r <= 1'b0;
            fidx_r   <= ptr_r[IDX_W-1:0];
            state_r  <= S_DONE;
          end else if (ptr_inc < cnt_x) begin
            ptr_r   <= ptr_inc;
            state_r <= S_FD_RD;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_status_r <= status_r;
            out_read_r   <= rd_ext[VAL_W-1:0];
            out_fidx_r   <= fidx_r;
            out_total_r  <= cnt_x[TOTAL_W-1:0];
            out_empty_r  <= (count_r == '0);
            out_full_r   <= (cnt_x >= cap_x);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_if.ready        = (state_r == S_IDLE);
  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.read_value  = out_read_r;
  assign out_if.found_index = out_fidx_r;
  assign out_if.entry_total = out_total_r;
  assign out_if.is_empty    = out_empty_r;
  assign out_if.is_full     = out_full_r;

`ifndef NO_ASSERTIONS
  // one command in flight: busy right after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_if.ready)
    else $error("list table took a beat while busy");

  // shift loop never reads past the last live entry
  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SH_RD || state_r == S_SH_WR) |-> (ptr_inc < cnt_x))
    else $error("remove shift pointer out of range");

  // count bounded by storage
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_x <= DEPTH_X)
    else $error("entry count exceeds depth");

  // a finished command shows up on the result channel next cycle
  a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (out_if.valid && in_if.ready))
    else $error("result not posted");
`endif

endmodule
